@@ design/i2cbs_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
package i2cbs_pkg;

  // Number of data bits in one byte on the bus.
  localparam int unsigned BITS_PER_BYTE = 8;

  // Phase counter width and phase landmarks.
  localparam int unsigned PHASE_W = 5;
  localparam logic [PHASE_W-1:0] WR_BIT_PHASES = PHASE_W'(3 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] WR_ACK_LOW    = PHASE_W'(3 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] WR_ACK_REL    = PHASE_W'(3 * BITS_PER_BYTE + 1);
  localparam logic [PHASE_W-1:0] RD_LAST       = PHASE_W'(3 + 2 * (BITS_PER_BYTE - 1) - 1);

  // Function codes carried by an input transfer.
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_ADDR  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;
  localparam logic [2:0] FUNC_CONT  = 3'd6;

  // Operation codes held in the sequencer state.
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd5;
  localparam logic [2:0] OP_CONT  = 3'd6;

  // Sub-phase codes within one written bit.
  localparam logic [1:0] SUB_CLK_LOW  = 2'd0;
  localparam logic [1:0] SUB_DATA     = 2'd1;
  localparam logic [1:0] SUB_CLK_HIGH = 2'd2;

  // Sequencer state.
  typedef struct packed {
    logic [2:0]         op;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         sub;
    logic [7:0]         shreg;
    logic               scl;
    logic               sda;
    logic               ack;
  } seq_state_t;

  // One result transfer.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy;
    logic       done;
    logic       ack_ok;
    logic [7:0] read_data;
    logic       rejected;
  } seq_result_t;

endpackage

@@ design/i2c_master_bit_sequencer_unit.sv @@
// Top level of the I2C master bit sequencer: state and result registers.
//
// Usage: each input transfer carries a function code and its operands.
// A command (start, stop, write byte, send address, read byte, continue
// acknowledge) is loaded only while the sequencer is idle; a command
// given while busy is dropped and its result flags rejected. Each tick
// transfer then steps one pin phase of the active command and samples
// sda_in_i where a bit is due.
// Every input transfer yields exactly one result transfer with the SCL
// and SDA levels, busy, and on the last phase done with the acknowledge
// or the read byte (MSB first).
// The result appears in the output register on the edge that accepts
// the item. One item is accepted per clock as long as the output
// register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and in_stall_o rises so no
// further item is taken. Reset releases both lines (high), clears the
// operation to idle and empties the output register.
module i2c_master_bit_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] data_i,
  input  logic [6:0] address_i,
  input  logic       read_flag_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       ack_ok_o,
  output logic [7:0] read_data_o,
  output logic       rejected_o
);
  import i2cbs_pkg::*;

  seq_state_t  state_q, state_d;
  seq_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_fire;

  // Accept when the output register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Step logic for one transfer.
  i2cbs_step u_step (
    .cur_i       (state_q),
    .func_i      (func_i),
    .data_i      (data_i),
    .address_i   (address_i),
    .read_flag_i (read_flag_i),
    .sda_in_i    (sda_in_i),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // Sequencer state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.op    <= OP_IDLE;
      state_q.phase <= '0;
      state_q.sub   <= SUB_CLK_LOW;
      state_q.shreg <= '0;
      state_q.scl   <= 1'b1;
      state_q.sda   <= 1'b1;
      state_q.ack   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = res_q.scl;
  assign sda_out_o   = res_q.sda_out;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_ok_o    = res_q.ack_ok;
  assign read_data_o = res_q.read_data;
  assign rejected_o  = res_q.rejected;

endmodule

@@ design/i2cbs_step.sv @@
// Next-state and result logic for one input transfer of the bit sequencer.
module i2cbs_step (
  input  i2cbs_pkg::seq_state_t  cur_i,
  input  logic [2:0]             func_i,
  input  logic [7:0]             data_i,
  input  logic [6:0]             address_i,
  input  logic                   read_flag_i,
  input  logic                   sda_in_i,
  output i2cbs_pkg::seq_state_t  nxt_o,
  output i2cbs_pkg::seq_result_t res_o
);
  import i2cbs_pkg::*;

  logic is_cmd;
  logic fin;

  // Codes one through six are commands; everything else acts as a tick.
  assign is_cmd = (func_i >= FUNC_START) && (func_i <= FUNC_CONT);

  // Command load or one pin phase of the active operation.
  always_comb begin
    nxt_o = cur_i;
    fin   = 1'b0;
    res_o = '0;

    if (is_cmd) begin
      if (cur_i.op != OP_IDLE) begin
        res_o.rejected = 1'b1;
      end else begin
        nxt_o.phase = '0;
        nxt_o.sub   = SUB_CLK_LOW;
        nxt_o.ack   = 1'b0;
        case (func_i)
          FUNC_WRITE: begin
            nxt_o.op    = OP_WRITE;
            nxt_o.shreg = data_i;
          end
          FUNC_ADDR: begin
            nxt_o.op    = OP_WRITE;
            nxt_o.shreg = {address_i, read_flag_i};
          end
          FUNC_READ: begin
            nxt_o.op    = OP_READ;
            nxt_o.shreg = '0;
          end
          default: begin
            nxt_o.op = func_i;
          end
        endcase
      end
    end else if (cur_i.op != OP_IDLE) begin
      case (cur_i.op)
        OP_START: begin
          case (cur_i.phase)
            5'd0: nxt_o.scl = 1'b0;
            5'd1: nxt_o.sda = 1'b1;
            5'd2: nxt_o.scl = 1'b1;
            default: begin
              nxt_o.sda = 1'b0;
              fin       = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          case (cur_i.phase)
            5'd0: nxt_o.scl = 1'b0;
            5'd1: nxt_o.sda = 1'b0;
            5'd2: nxt_o.scl = 1'b1;
            default: begin
              nxt_o.sda = 1'b1;
              fin       = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          if (cur_i.phase < WR_BIT_PHASES) begin
            // Three phases per bit, tracked by the sub-phase counter.
            nxt_o.sub = (cur_i.sub == SUB_CLK_HIGH) ? SUB_CLK_LOW : cur_i.sub + 2'd1;
            case (cur_i.sub)
              SUB_CLK_LOW: nxt_o.scl = 1'b0;
              SUB_DATA:    nxt_o.sda = cur_i.shreg[7];
              default: begin
                nxt_o.scl   = 1'b1;
                nxt_o.shreg = {cur_i.shreg[6:0], 1'b0};
              end
            endcase
          end else if (cur_i.phase == WR_ACK_LOW) begin
            nxt_o.scl = 1'b0;
          end else if (cur_i.phase == WR_ACK_REL) begin
            nxt_o.sda = 1'b1;
          end else begin
            nxt_o.scl = 1'b1;
            nxt_o.ack = ~sda_in_i;
            fin       = 1'b1;
          end
        end
        OP_READ: begin
          if (cur_i.phase == 5'd0) begin
            nxt_o.scl = 1'b0;
          end else if (cur_i.phase == 5'd1) begin
            nxt_o.sda = 1'b1;
          end else if (cur_i.phase == 5'd2) begin
            nxt_o.scl   = 1'b1;
            nxt_o.shreg = {7'd0, sda_in_i};
          end else if (cur_i.phase[0]) begin
            // Odd phases past the first sample drive the clock low.
            nxt_o.scl = 1'b0;
          end else begin
            nxt_o.scl   = 1'b1;
            nxt_o.shreg = {cur_i.shreg[6:0], sda_in_i};
            fin         = (cur_i.phase >= RD_LAST);
          end
        end
        OP_CONT: begin
          case (cur_i.phase)
            5'd0: nxt_o.scl = 1'b0;
            5'd1: nxt_o.sda = 1'b0;
            default: begin
              nxt_o.scl = 1'b1;
              fin       = 1'b1;
            end
          endcase
        end
        default: begin
          fin = 1'b1;
        end
      endcase

      nxt_o.phase = cur_i.phase + 5'd1;
      if (fin) begin
        res_o.done = 1'b1;
        if (cur_i.op == OP_WRITE) begin
          res_o.ack_ok = nxt_o.ack;
        end
        if (cur_i.op == OP_READ) begin
          res_o.read_data = nxt_o.shreg;
        end
        nxt_o.op    = OP_IDLE;
        nxt_o.phase = '0;
      end
    end

    // Line levels and busy reflect the state after this step.
    res_o.scl     = nxt_o.scl;
    res_o.sda_out = nxt_o.sda;
    res_o.busy    = (nxt_o.op != OP_IDLE);
  end

endmodule
